[rtl/vrsp_pkg.sv]
// Shared types and constants for the variable-rate sample player.
// No dependencies; every other rtl file imports this package.
package vrsp_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SPEED_W    = 24;
   localparam int SPEED_FRAC = 16;
   localparam int COUNT_W    = 17;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT = 1'd1;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_PLAY    = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_PLAY = 1'b1
   } entry_kind_type;

   typedef enum logic {
      PH_FIRST  = 1'b0,
      PH_SECOND = 1'b1
   } phase_type;

   typedef struct packed {
      logic               loop_enable;
      logic [COUNT_W-1:0] sample_count;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/variable_rate_sample_player_unit.sv]
// Variable-rate sample player: linear-interpolating playback of loaded
// signed 16-bit samples. Load requests write the next sample while the
// store has room; play requests advance a fixed-point read position by speed
// (Q8.16), saturating at its maximum, and return one response interpolated
// between the samples at integer+1 and integer+2, rounded toward minus
// infinity; addresses at or past sample_count read as zero. Past the end,
// a play either wraps to position zero (loop_enable) or returns zero with
// ended set. Restart requests clear position and load pointer and return
// nothing. A play occupies the single-port sample memory for both its reads;
// loads retire at one per cycle while no play holds the port. After a play
// leaves the queue, its result passes the a, b and response registers, which
// hold while the response is stalled, before rsp_tvalid rises. A two-entry
// queue separates the request front end from the memory back end, and
// req_tready drops only while it is full. Never-loaded sample entries read
// back undefined; there is no clearing pass. Write configuration only while
// no request is in flight.
// Depends on vrsp_pkg, vrsp_front, vrsp_queue and vrsp_back.
module variable_rate_sample_player_unit #(
   parameter int ADDR_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [39:0]                           req_tdata,  // load_sample[15:0], speed[39:16]
   input  logic [1:0]                            req_tuser,  // operation[1:0]
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,  // sample_out[15:0]
   output logic                                  rsp_tuser,  // ended[0]
   // configuration writes
   input  logic                                  csr_we,
   input  logic [vrsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [vrsp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import vrsp_pkg::*;

   localparam int ENTRY_W = ADDR_BITS + FRAC_BITS + SAMPLE_W + 4;

   cfg_type            cfg_ff;
   queue_status_type   q_status;
   logic               q_push, q_pop;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   // Latch configuration registers; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOOP_ENABLE:  cfg_ff.loop_enable  <= csr_wdata[0];
            CSR_SAMPLE_COUNT: cfg_ff.sample_count <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Front end: classify requests, advance position, push work.
   vrsp_front #(
      .ADDR_BITS (ADDR_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   // Hold up to two pending loads or plays.
   vrsp_queue #(
      .ENTRY_W (ENTRY_W)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // Back end: sample memory, interpolation and response register.
   vrsp_back #(
      .ADDR_BITS (ADDR_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rdata    (q_rdata),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef ASSERT_OFF
   // An ended response always carries a zero sample.
   a_ended_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("ended response with nonzero sample");

   // The queue cannot be full and empty at once.
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty");

   // With the queue empty, requests must be taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> req_tready)
      else $error("request stalled with empty queue");
`endif

endmodule

[rtl/vrsp_front.sv]
// Front end: accepts requests, tracks load pointer and read position, turns each
// play and each load that fits the store into a queue entry. Depends on vrsp_pkg.
module vrsp_front #(
   parameter int ADDR_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  vrsp_pkg::cfg_type                      cfg,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [39:0]                            req_tdata,
   input  logic [1:0]                             req_tuser,
   input  vrsp_pkg::queue_status_type             q_status,
   output logic                                   q_push,
   output logic [ADDR_BITS+FRAC_BITS+vrsp_pkg::SAMPLE_W+3:0] q_wdata
);
   import vrsp_pkg::*;

   localparam int PW  = ADDR_BITS + 1 + FRAC_BITS;
   localparam int IW  = ADDR_BITS + 1;
   localparam int CW  = ((IW > COUNT_W) ? IW : COUNT_W) + 1;
   localparam int SHL = (FRAC_BITS >= SPEED_FRAC) ? FRAC_BITS - SPEED_FRAC : 0;
   localparam int SHR = (FRAC_BITS >= SPEED_FRAC) ? 0 : SPEED_FRAC - FRAC_BITS;
   localparam logic [CW-1:0] DEPTH_CW = CW'(1) << ADDR_BITS;

   typedef struct packed {
      entry_kind_type          kind;
      logic                    ended;
      logic                    v1;
      logic                    v2;
      logic [ADDR_BITS-1:0]    addr;
      logic [FRAC_BITS-1:0]    frac;
      logic [SAMPLE_W-1:0]     data;
   } entry_type;

   logic [PW-1:0]       pos_ff, pos_in;
   logic [IW-1:0]       ptr_ff, ptr_in;
   logic [SAMPLE_W-1:0] load_sample;
   logic [SPEED_W-1:0]  speed;
   op_type              op;
   logic                accept;
   logic [PW-1:0]       inc;
   logic [PW:0]         sum_ext;
   logic [PW-1:0]       adv;
   logic [IW-1:0]       ipart;
   logic                past_end, wrap;
   logic [CW-1:0]       a1, a2, count_cw;
   entry_type           entry;

   assign load_sample = req_tdata[15:0];
   assign speed       = req_tdata[39:16];
   assign op          = op_type'(req_tuser);
   assign req_tready  = !q_status.full;
   assign accept      = req_tvalid && req_tready;
   assign count_cw    = CW'(cfg.sample_count);

   always_comb begin
      // Align Q8.16 speed to the position's fraction, then advance and saturate.
      inc      = PW'(PW'(speed >> SHR) << SHL);
      sum_ext  = {1'b0, pos_ff} + {1'b0, inc};
      adv      = sum_ext[PW] ? '1 : sum_ext[PW-1:0];
      ipart    = adv[PW-1:FRAC_BITS];
      past_end = CW'(ipart) > count_cw;
      wrap     = past_end && cfg.loop_enable;

      entry       = '0;
      entry.kind  = KIND_PLAY;
      entry.ended = past_end && !cfg.loop_enable;
      entry.frac  = wrap ? '0 : adv[FRAC_BITS-1:0];
      a1          = (wrap ? '0 : CW'(ipart)) + CW'(1);
      a2          = a1 + CW'(1);
      entry.addr  = a1[ADDR_BITS-1:0];
      entry.v1    = !entry.ended && (a1 < count_cw) && (a1 < DEPTH_CW);
      entry.v2    = !entry.ended && (a2 < count_cw) && (a2 < DEPTH_CW);

      pos_in = pos_ff;
      ptr_in = ptr_ff;
      q_push = 1'b0;
      case (op)
         OP_LOAD: begin
            entry.kind = KIND_LOAD;
            entry.addr = ptr_ff[ADDR_BITS-1:0];
            entry.data = load_sample;
            if (!ptr_ff[ADDR_BITS]) begin
               q_push = accept;
               ptr_in = ptr_ff + IW'(1);
            end
         end
         OP_PLAY: begin
            q_push = accept;
            pos_in = wrap ? '0 : adv;
         end
         OP_RESTART: begin
            pos_in = '0;
            ptr_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign q_wdata = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ptr_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         ptr_ff <= ptr_in;
      end
   end

endmodule

[rtl/vrsp_queue.sv]
// Two-entry queue between front and back end.
// Depends on vrsp_pkg for depth constants and the status struct.
module vrsp_queue #(
   parameter int ENTRY_W = 52
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [ENTRY_W-1:0]         wdata,
   input  logic                       pop,
   output logic [ENTRY_W-1:0]         rdata,
   output vrsp_pkg::queue_status_type status
);
   import vrsp_pkg::*;

   logic [ENTRY_W-1:0] ent_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] cnt_ff;
   logic               do_push, do_pop;

   assign status.full  = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         cnt_ff <= cnt_ff + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
      end
   end

endmodule

[rtl/vrsp_back.sv]
// Back end: owns the single-port sample memory, performs loads and the two
// reads of each play, interpolates and drives the response register.
// Depends on vrsp_pkg.
module vrsp_back #(
   parameter int ADDR_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [ADDR_BITS+FRAC_BITS+vrsp_pkg::SAMPLE_W+3:0] q_rdata,
   input  vrsp_pkg::queue_status_type             q_status,
   output logic                                   q_pop,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [15:0]                            rsp_tdata,
   output logic                                   rsp_tuser
);
   import vrsp_pkg::*;

   localparam int DEPTH  = 1 << ADDR_BITS;
   localparam int PROD_W = FRAC_BITS + 1 + SAMPLE_W + 1;

   typedef struct packed {
      entry_kind_type          kind;
      logic                    ended;
      logic                    v1;
      logic                    v2;
      logic [ADDR_BITS-1:0]    addr;
      logic [FRAC_BITS-1:0]    frac;
      logic [SAMPLE_W-1:0]     data;
   } entry_type;

   entry_type               head;
   phase_type               phase_ff, phase_in;
   logic                    go, mem_we, mem_re, a_load;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [SAMPLE_W-1:0]     mem [DEPTH];
   logic [SAMPLE_W-1:0]     rd_ff;

   logic                    a_valid_ff, a_v2_ff, a_ended_ff;
   logic [SAMPLE_W-1:0]     a_s1_ff;
   logic [FRAC_BITS-1:0]    a_frac_ff;
   logic                    b_valid_ff, b_ended_ff;
   logic [SAMPLE_W-1:0]     b_s1_ff;
   logic signed [PROD_W-1:0] b_prod_ff, prod_in, frac_ext, diff_ext;
   logic signed [SAMPLE_W:0] diff, step;
   logic [SAMPLE_W-1:0]     s2;
   logic [SAMPLE_W:0]       sum;
   logic                    rsp_valid_ff, rsp_ended_ff;
   logic [SAMPLE_W-1:0]     rsp_data_ff;

   assign head = q_rdata;
   assign go   = !rsp_valid_ff || rsp_tready;

   // Loads use the port whenever it is free; a play takes it for both of its reads.
   always_comb begin
      phase_in = phase_ff;
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      a_load   = 1'b0;
      rd_addr  = head.addr;
      case (phase_ff)
         PH_FIRST: begin
            if (!q_status.empty) begin
               if (head.kind == KIND_LOAD) begin
                  mem_we = 1'b1;
                  q_pop  = 1'b1;
               end else if (go) begin
                  mem_re   = 1'b1;
                  phase_in = PH_SECOND;
               end
            end
         end
         PH_SECOND: begin
            if (go) begin
               mem_re   = 1'b1;
               rd_addr  = head.addr + ADDR_BITS'(1);
               q_pop    = 1'b1;
               a_load   = 1'b1;
               phase_in = PH_FIRST;
            end
         end
         default: phase_in = PH_FIRST;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= PH_FIRST;
      else       phase_ff <= phase_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[head.addr] <= head.data;
      if (mem_re) rd_ff <= mem[rd_addr];
   end

   // Interpolate as s1 + floor(frac * (s2 - s1) / 2^FRAC_BITS).
   always_comb begin
      s2       = a_v2_ff ? rd_ff : '0;
      diff     = $signed({s2[SAMPLE_W-1], s2}) - $signed({a_s1_ff[SAMPLE_W-1], a_s1_ff});
      frac_ext = {{(PROD_W-FRAC_BITS){1'b0}}, a_frac_ff};
      diff_ext = {{(PROD_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff};
      prod_in  = frac_ext * diff_ext;
      step     = b_prod_ff[FRAC_BITS+SAMPLE_W:FRAC_BITS];
      sum      = {b_s1_ff[SAMPLE_W-1], b_s1_ff} + step;
   end

   always_ff @(posedge clock) begin
      if (go && a_load) begin
         a_s1_ff    <= head.v1 ? rd_ff : '0;
         a_v2_ff    <= head.v2;
         a_frac_ff  <= head.frac;
         a_ended_ff <= head.ended;
      end
      if (go) begin
         b_prod_ff    <= prod_in;
         b_s1_ff      <= a_s1_ff;
         b_ended_ff   <= a_ended_ff;
         rsp_data_ff  <= sum[SAMPLE_W-1:0];
         rsp_ended_ff <= b_ended_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         a_valid_ff   <= a_load;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ended_ff;

endmodule

[tb/variable_rate_sample_player_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for variable_rate_sample_player_unit: a scoreboard class
// predicts every play response; tasks drive requests and CSRs, a loop takes responses.
// Depends on vrsp_pkg and the variable_rate_sample_player_unit RTL.

typedef struct packed {
   logic [15:0] sample;
   logic        ended;
} playback_result_type;

class playback_scoreboard;
   logic [15:0]         sample_mem [65536];
   logic [16:0]         load_ptr;
   logic [32:0]         position;   // 17 integer bits, 16 fraction bits
   logic                loop_on;
   logic [16:0]         count;
   int                  written_top;  // every entry below this has been loaded once
   int                  failures;
   playback_result_type expected[$];

   function new();
      load_ptr    = '0;
      position    = '0;
      loop_on     = 1'b0;
      count       = '0;
      written_top = 0;
      failures    = 0;
   endfunction

   function int pending();
      return expected.size();
   endfunction

   function void set_register(logic [vrsp_pkg::CSR_INDEX_W-1:0] index, logic [16:0] value);
      if (index == vrsp_pkg::CSR_LOOP_ENABLE)
         loop_on = value[0];
      else if (index == vrsp_pkg::CSR_SAMPLE_COUNT)
         count = value;
   endfunction

   // Anything at or past the count, or past the store, reads as zero.
   function longint stored_sample(logic [17:0] addr);
      if (addr >= {1'b0, count} || addr[17:16] != 2'b00)
         return 0;
      return longint'($signed(sample_mem[addr[15:0]]));
   endfunction

   function void note_request(logic [1:0] op, logic [15:0] smp, logic [23:0] spd);
      logic [33:0]         sum;
      logic [16:0]         ipart;
      longint              frac;
      longint              s1;
      longint              s2;
      longint              acc;
      playback_result_type r;
      case (op)
         vrsp_pkg::OP_LOAD: begin
            // bit 16 set means the store is full: drop the load
            if (!load_ptr[16]) begin
               sample_mem[load_ptr[15:0]] = smp;
               load_ptr = load_ptr + 17'd1;
               if (int'(load_ptr) > written_top)
                  written_top = int'(load_ptr);
            end
         end
         vrsp_pkg::OP_RESTART: begin
            position = '0;
            load_ptr = '0;
         end
         vrsp_pkg::OP_PLAY: begin
            // speed is Q8.16 and the position has 16 fraction bits: no realignment
            sum      = {1'b0, position} + {10'b0, spd};
            position = sum[33] ? '1 : sum[32:0];
            if (position[32:16] > count) begin
               if (loop_on) begin
                  position = '0;
               end else begin
                  r.sample = '0;
                  r.ended  = 1'b1;
                  expected.push_back(r);
                  return;
               end
            end
            ipart = position[32:16];
            frac  = longint'(position[15:0]);
            s1    = stored_sample({1'b0, ipart} + 18'd1);
            s2    = stored_sample({1'b0, ipart} + 18'd2);
            acc   = (65536 - frac) * s1 + frac * s2;
            acc   = acc >>> 16;   // floor
            r.sample = acc[15:0];
            r.ended  = 1'b0;
            expected.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function void check_response(logic [15:0] smp, logic ended);
      playback_result_type want;
      if (expected.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected response: sample %0d ended %0b", $signed(smp), ended);
         return;
      end
      want = expected.pop_front();
      if (want.sample !== smp || want.ended !== ended) begin
         failures++;
         if (failures <= 10)
            $display("response mismatch: expected sample %0d ended %0b, got sample %0d ended %0b",
                     $signed(want.sample), want.ended, $signed(smp), ended);
      end
   endfunction
endclass

module variable_rate_sample_player_unit_test;
   import vrsp_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         CYCLE_LIMIT  = 500_000;
   localparam int         DRAIN_CYCLES = 16;
   localparam int         RANDOM_ITEMS = 1250;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [39:0]            req_tdata  = '0;  // load_sample[15:0], speed[39:16]
   logic [1:0]             req_tuser  = '0;  // operation[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;        // sample_out[15:0]
   logic                   rsp_tuser;        // ended[0]
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   playback_scoreboard sb;
   int     cycle_count  = 0;
   int     random_items = 0;
   bit     counting     = 1'b0;  // count requests toward the random budget
   bit     req_idle_on  = 1'b1;
   bit     rsp_idle_on  = 1'b1;

   variable_rate_sample_player_unit #(
      .ADDR_BITS(16),
      .FRAC_BITS(16)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Abort a hung run well past the slowest legal schedule.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one request after a random gap and hold it until the block takes it.
   task automatic send_request(input logic [1:0] op, input logic [15:0] smp,
                               input logic [23:0] spd);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {spd, smp};
      req_tuser  <= op;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(op, smp, spd);
      if (counting && op != OP_UNUSED)
         random_items++;
   endtask

   task automatic send_play(input logic [23:0] spd);
      send_request(OP_PLAY, 16'($urandom), spd);
   endtask

   // Drop valid, drain every expected response, then let loads still in the
   // queue retire before anything touches the CSRs.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; only call this with the block idle.
   task automatic configure(input logic loop_value, input logic [16:0] count_value);
      csr_we    <= 1'b1;
      csr_index <= CSR_LOOP_ENABLE;
      csr_wdata <= {16'b0, loop_value};
      @(posedge clock);
      sb.set_register(CSR_LOOP_ENABLE, {16'b0, loop_value});
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= count_value;
      @(posedge clock);
      sb.set_register(CSR_SAMPLE_COUNT, count_value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly speeds that walk a few samples per step, plus zero, maximum and noise.
   function automatic logic [23:0] pick_speed();
      case ($urandom_range(0, 15))
         0:       return 24'd0;
         1:       return 24'hFFFFFF;
         2, 3:    return 24'($urandom);
         default: return 24'($urandom_range(0, 24'h030000));
      endcase
   endfunction

   // Response side: stall a random number of cycles before each response.
   initial begin
      int stall;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int          phase;
      int          n;
      int          top;
      int          k;
      logic [16:0] count_value;

      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Registers are still at reset: no loop, count zero.
      send_play(24'd0);              // nothing stored: reads past the count give zero
      send_play(24'h010000);         // integer part 1 exceeds count 0: ended
      send_request(OP_UNUSED, 16'($urandom), 24'($urandom));
      send_request(OP_RESTART, 16'($urandom), 24'($urandom));
      send_request(OP_LOAD, 16'h8000, 24'($urandom));
      send_request(OP_LOAD, 16'h7FFF, 24'($urandom));
      send_request(OP_LOAD, 16'h8000, 24'($urandom));
      send_request(OP_LOAD, 16'h7FFF, 24'($urandom));
      send_request(OP_LOAD, 16'hFFFF, 24'($urandom));
      send_request(OP_LOAD, 16'h0000, 24'($urandom));
      send_request(OP_LOAD, 16'h0001, 24'($urandom));
      send_request(OP_LOAD, 16'h1234, 24'($urandom));
      wait_quiet();
      configure(1'b1, 17'd8);
      send_request(OP_RESTART, 16'($urandom), 24'($urandom));
      send_play(24'd0);              // full-scale extremes, zero fraction
      send_play(24'h008000);         // half way between extremes: floor rounding
      send_play(24'h000001);         // smallest step
      send_play(24'h00FFFF);
      send_play(24'hFFFFFF);         // far past the end: wrap to zero
      send_play(24'h070000);         // both reads at or past the count
      send_play(24'h010000);         // integer part equals count: still plays
      send_play(24'h010000);         // one more: wrap
      wait_quiet();
      configure(1'b0, 17'd8);
      send_play(24'hFFFFFF);         // past the end without loop
      send_play(24'hFFFFFF);         // position kept, still ended
      send_request(OP_RESTART, 16'($urandom), 24'($urandom));
      send_play(24'h030000);
      wait_quiet();

      // Random part: load a short clip, configure, restart and play it with noise.
      counting = 1'b1;
      phase    = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 5) begin
            // Run away past a short clip at top speed until the position saturates.
            configure(1'b0, 17'd3);
            send_request(OP_RESTART, 16'($urandom), 24'($urandom));
            repeat (520) send_play(24'hFFFFFF);
            wait_quiet();
         end else begin
            if ($urandom_range(0, 9) != 0)
               send_request(OP_RESTART, 16'($urandom), 24'($urandom));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            repeat (n) begin
               if ($urandom_range(0, 19) == 0)
                  send_request(OP_UNUSED, 16'($urandom), 24'($urandom));
               send_request(OP_LOAD, 16'($urandom), 24'($urandom));
            end
            wait_quiet();
            // Keep the count inside what has been loaded so no blank entry is read.
            top = sb.written_top;
            case ($urandom_range(0, 9))
               0:       count_value = 17'd0;
               1:       count_value = 17'(top);
               2:       count_value = 17'($urandom_range(0, top));
               default: count_value = 17'($urandom_range(0, (top < 64) ? top : 64));
            endcase
            configure(1'($urandom_range(0, 1)), count_value);
            send_request(OP_RESTART, 16'($urandom), 24'($urandom));
            n = $urandom_range(8, 60);
            repeat (n) begin
               k = $urandom_range(0, 99);
               if (k < 90)
                  send_play(pick_speed());
               else if (k < 94)
                  send_request(OP_LOAD, 16'($urandom), 24'($urandom));
               else if (k < 97)
                  send_request(OP_UNUSED, 16'($urandom), 24'($urandom));
               else
                  send_request(OP_RESTART, 16'($urandom), 24'($urandom));
            end
            wait_quiet();
         end
      end

      wait_quiet();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/vrsp_pkg.sv
rtl/vrsp_front.sv
rtl/vrsp_queue.sv
rtl/vrsp_back.sv
rtl/variable_rate_sample_player_unit.sv
tb/variable_rate_sample_player_unit_test.sv
